FILE: src/lsf_pkg.sv
// ============================================================================
// lsf_pkg
// Shared types and constants of the linear sieve factoriser: field widths,
// table geometry, result status codes and the sequencer state encoding.
// ============================================================================
package lsf_pkg;

    // Value and table geometry
    localparam int VAL_W       = 12;
    localparam int MAX_VALUE   = 4095;
    localparam int TBL_DEPTH   = MAX_VALUE + 1;
    localparam int TBL_AW      = $clog2(TBL_DEPTH);
    localparam int PROD_W      = 2 * VAL_W;

    // Prime store geometry and counters
    localparam int PRIME_DEPTH = 1024;
    localparam int PIDX_W      = $clog2(PRIME_DEPTH);
    localparam int SCNT_W      = $clog2(PRIME_DEPTH + 1);
    localparam int PCNT_W      = 11;
    localparam int PCNT_MAX    = (1 << PCNT_W) - 1;

    // Results per query
    localparam int MAX_RESULTS = 11;
    localparam int KCNT_W      = $clog2(MAX_RESULTS);

    // Operation codes
    localparam logic OP_BUILD  = 1'b0;
    localparam logic OP_FACTOR = 1'b1;

    // Result status codes
    localparam int STAT_W = 3;
    localparam logic [STAT_W-1:0] ST_FACTOR    = 3'd0;
    localparam logic [STAT_W-1:0] ST_BUILT     = 3'd1;
    localparam logic [STAT_W-1:0] ST_ONE       = 3'd2;
    localparam logic [STAT_W-1:0] ST_RANGE     = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_BUILT = 3'd4;

    typedef struct packed {
        logic             operation;
        logic [VAL_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  factor;
        logic [PCNT_W-1:0] prime_count;
        logic              last;
    } out_item_t;

    // One table entry: smallest prime factor and the cofactor value/spf
    typedef struct packed {
        logic [VAL_W-1:0] spf;
        logic [VAL_W-1:0] cof;
    } spf_entry_t;

    typedef struct packed {
        logic              valid;
        out_item_t         item;
    } emit_t;

    typedef struct packed {
        logic              we;
        logic [TBL_AW-1:0] waddr;
        spf_entry_t        wdata;
        logic [TBL_AW-1:0] raddr;
    } tbl_req_t;

    typedef struct packed {
        logic              we;
        logic [PIDX_W-1:0] waddr;
        logic [VAL_W-1:0]  wdata;
        logic [PIDX_W-1:0] raddr;
    } pr_req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_SIEVE_RD,
        S_SIEVE_CHK,
        S_PRIME_RD,
        S_MUL,
        S_STRIKE,
        S_BUILD_DONE,
        S_REJECT,
        S_F_RD,
        S_F_CHK
    } seq_state_t;

endpackage

FILE: src/lsf_ram.sv
// ============================================================================
// lsf_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ============================================================================
module lsf_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/lsf_outreg.sv
// ============================================================================
// lsf_outreg
// Output register of the result channel: holds one result while the
// receiver stalls and frees the sequencer as soon as the slot empties.
// ============================================================================
module lsf_outreg
    import lsf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  emit_t     emit,
    output logic      out_free,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_data_reg;
    out_item_t out_data_next;

    assign out_free = !out_valid_reg || !out_stall;

    // Load a new result when the slot is empty or being transferred
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_free)
        begin
            out_valid_next = emit.valid;
            if (emit.valid)
            begin
                out_data_next = emit.item;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: src/lsf_seq.sv
// ============================================================================
// lsf_seq
// Sequencer of the factoriser: clears and sieves the factor table through
// its RAM port, keeps the prime store, and walks the table for queries.
// ============================================================================
module lsf_seq
    import lsf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    input  logic [VAL_W-1:0] sieve_limit,
    output emit_t            emit,
    input  logic             out_free,
    output tbl_req_t         tbl_req,
    input  spf_entry_t       tbl_rdata,
    output pr_req_t          pr_req,
    input  logic [VAL_W-1:0] pr_rdata
);

    seq_state_t          state_reg,       state_next;
    logic [VAL_W-1:0]    lim_reg,         lim_next;
    logic [VAL_W-1:0]    built_limit_reg, built_limit_next;
    logic [VAL_W-1:0]    idx_reg,         idx_next;
    logic [SCNT_W-1:0]   stored_reg,      stored_next;
    logic [SCNT_W-1:0]   j_reg,           j_next;
    logic [VAL_W-1:0]    spf_i_reg,       spf_i_next;
    logic [VAL_W-1:0]    p_reg,           p_next;
    logic [PROD_W-1:0]   prod_reg,        prod_next;
    logic [KCNT_W-1:0]   k_reg,           k_next;
    logic [STAT_W-1:0]   stat_reg,        stat_next;

    logic                accept;
    logic [VAL_W-1:0]    lim_clamped;
    logic [PCNT_W-1:0]   count_sat;
    logic                fact_last;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    // Clamp the configured limit into the sieve range
    always_comb
    begin
        if (sieve_limit < VAL_W'(2))
        begin
            lim_clamped = VAL_W'(2);
        end
        else if ({1'b0, sieve_limit} > (VAL_W + 1)'(MAX_VALUE))
        begin
            lim_clamped = VAL_W'(MAX_VALUE);
        end
        else
        begin
            lim_clamped = sieve_limit;
        end
    end

    assign count_sat = (int'(stored_reg) > PCNT_MAX) ? PCNT_W'(PCNT_MAX)
                                                     : PCNT_W'(stored_reg);
    assign fact_last = (tbl_rdata.cof == VAL_W'(1))
                       || (k_reg == KCNT_W'(MAX_RESULTS - 1));

    // Next state, memory requests and results
    always_comb
    begin
        state_next       = state_reg;
        lim_next         = lim_reg;
        built_limit_next = built_limit_reg;
        idx_next         = idx_reg;
        stored_next      = stored_reg;
        j_next           = j_reg;
        spf_i_next       = spf_i_reg;
        p_next           = p_reg;
        prod_next        = prod_reg;
        k_next           = k_reg;
        stat_next        = stat_reg;

        tbl_req.we       = 1'b0;
        tbl_req.waddr    = TBL_AW'(idx_reg);
        tbl_req.wdata    = '0;
        tbl_req.raddr    = TBL_AW'(idx_reg);
        pr_req.we        = 1'b0;
        pr_req.waddr     = PIDX_W'(stored_reg);
        pr_req.wdata     = idx_reg;
        pr_req.raddr     = PIDX_W'(j_reg);

        emit             = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.operation == OP_BUILD)
                    begin
                        lim_next    = lim_clamped;
                        idx_next    = '0;
                        stored_next = '0;
                        state_next  = S_CLEAR;
                    end
                    else if (built_limit_reg == '0)
                    begin
                        stat_next  = ST_NOT_BUILT;
                        state_next = S_REJECT;
                    end
                    else if (in_data.value == '0 || in_data.value > built_limit_reg)
                    begin
                        stat_next  = ST_RANGE;
                        state_next = S_REJECT;
                    end
                    else if (in_data.value == VAL_W'(1))
                    begin
                        stat_next  = ST_ONE;
                        state_next = S_REJECT;
                    end
                    else
                    begin
                        idx_next   = in_data.value;
                        k_next     = '0;
                        state_next = S_F_RD;
                    end
                end
            end

            // Zero the table entries up to the limit, one a cycle
            S_CLEAR:
            begin
                tbl_req.we = 1'b1;
                if (idx_reg == lim_reg)
                begin
                    idx_next   = VAL_W'(2);
                    state_next = S_SIEVE_RD;
                end
                else
                begin
                    idx_next = idx_reg + VAL_W'(1);
                end
            end

            S_SIEVE_RD:
            begin
                state_next = S_SIEVE_CHK;
            end

            // An untouched entry is a prime: mark it and store it
            S_SIEVE_CHK:
            begin
                if (tbl_rdata.spf == '0)
                begin
                    tbl_req.we        = 1'b1;
                    tbl_req.wdata.spf = idx_reg;
                    tbl_req.wdata.cof = VAL_W'(1);
                    spf_i_next        = idx_reg;
                    if (int'(stored_reg) < PRIME_DEPTH)
                    begin
                        pr_req.we   = 1'b1;
                        stored_next = stored_reg + SCNT_W'(1);
                    end
                end
                else
                begin
                    spf_i_next = tbl_rdata.spf;
                end
                j_next     = '0;
                state_next = S_PRIME_RD;
            end

            S_PRIME_RD:
            begin
                if (j_reg >= stored_reg)
                begin
                    if (idx_reg == lim_reg)
                    begin
                        state_next = S_BUILD_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + VAL_W'(1);
                        state_next = S_SIEVE_RD;
                    end
                end
                else
                begin
                    state_next = S_MUL;
                end
            end

            S_MUL:
            begin
                p_next     = pr_rdata;
                prod_next  = PROD_W'(idx_reg) * PROD_W'(pr_rdata);
                state_next = S_STRIKE;
            end

            // Strike i*p with p as its smallest factor, stop at spf(i) or past the limit
            S_STRIKE:
            begin
                if (prod_reg > PROD_W'(lim_reg) || p_reg == spf_i_reg)
                begin
                    if (prod_reg <= PROD_W'(lim_reg))
                    begin
                        tbl_req.we        = 1'b1;
                        tbl_req.waddr     = TBL_AW'(prod_reg);
                        tbl_req.wdata.spf = p_reg;
                        tbl_req.wdata.cof = idx_reg;
                    end
                    if (idx_reg == lim_reg)
                    begin
                        state_next = S_BUILD_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + VAL_W'(1);
                        state_next = S_SIEVE_RD;
                    end
                end
                else
                begin
                    tbl_req.we        = 1'b1;
                    tbl_req.waddr     = TBL_AW'(prod_reg);
                    tbl_req.wdata.spf = p_reg;
                    tbl_req.wdata.cof = idx_reg;
                    j_next            = j_reg + SCNT_W'(1);
                    state_next        = S_PRIME_RD;
                end
            end

            S_BUILD_DONE:
            begin
                emit.valid            = 1'b1;
                emit.item.status      = ST_BUILT;
                emit.item.prime_count = count_sat;
                emit.item.last        = 1'b1;
                if (out_free)
                begin
                    built_limit_next = lim_reg;
                    state_next       = S_IDLE;
                end
            end

            S_REJECT:
            begin
                emit.valid       = 1'b1;
                emit.item.status = stat_reg;
                emit.item.last   = 1'b1;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            S_F_RD:
            begin
                state_next = S_F_CHK;
            end

            // Emit the smallest factor and move on to the cofactor; a bad entry ends as out of range
            S_F_CHK:
            begin
                emit.valid = 1'b1;
                if (tbl_rdata.spf < VAL_W'(2))
                begin
                    emit.item.status = ST_RANGE;
                    emit.item.last   = 1'b1;
                    if (out_free)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    emit.item.status = ST_FACTOR;
                    emit.item.factor = tbl_rdata.spf;
                    emit.item.last   = fact_last;
                    if (out_free)
                    begin
                        if (fact_last)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            idx_next   = tbl_rdata.cof;
                            k_next     = k_reg + KCNT_W'(1);
                            state_next = S_F_RD;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            built_limit_reg <= '0;
            stored_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            built_limit_reg <= built_limit_next;
            stored_reg      <= stored_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        lim_reg   <= lim_next;
        idx_reg   <= idx_next;
        j_reg     <= j_next;
        spf_i_reg <= spf_i_next;
        p_reg     <= p_next;
        prod_reg  <= prod_next;
        k_reg     <= k_next;
        stat_reg  <= stat_next;
    end

    // An accepted item always occupies the sequencer in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("item accepted but sequencer not busy");

    // A query never walks past the result limit
    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_F_CHK |-> k_reg <= KCNT_W'(MAX_RESULTS - 1))
        else $error("factor count beyond limit");

    // Strike writes stay inside the sieved range
    a_strike_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_STRIKE && tbl_req.we |-> prod_reg <= PROD_W'(lim_reg))
        else $error("strike outside limit");

    // Only factor results can be followed by further results
    a_nonfactor_last: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid && emit.item.status != ST_FACTOR |-> emit.item.last)
        else $error("non-factor result without last");

    // A finished build leaves the table marked as built
    a_built_mark: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid && out_free && emit.item.status == ST_BUILT
        |=> built_limit_reg >= VAL_W'(2))
        else $error("build done but limit not recorded");

endmodule

FILE: src/linear_sieve_factorizer_core.sv
// ============================================================================
// linear_sieve_factorizer_core
// Smallest-prime-factor table built by the linear sieve, with table-driven
// factorisation of query values.
// ============================================================================
// Channels: config (cfg_valid/cfg_ready/cfg_data) writes the sieve limit and
// is always ready; write it only while the block is idle. Input items and
// results move on valid/stall channels; a transfer happens when valid is
// high and stall is low.
// A build item clears table entries 0..limit, then sieves the values
// from 2 to the limit against the stored primes and gives one result
// with the prime count. The factor table RAM has one write port and one
// registered read port, shared by the clear, the sieve and the queries.
// A factor item gives one result per prime factor, at most 11 (one
// table read per factor, cofactor comes from the same entry); the first
// result goes through the S_F_RD and S_F_CHK states into the output
// register, and a rejected query's result through S_REJECT.
// One item is worked at a time; in_stall is high from the transfer until
// its last result is in the output register. A stalled receiver holds the
// output register and, once it is full, the sequencer waits.
// Reset leaves the block unbuilt (queries answer "not built") and sets the
// limit to its maximum; the table needs no clearing pass at reset.
// ============================================================================
module linear_sieve_factorizer_core
    import lsf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [VAL_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data
);

    logic [VAL_W-1:0] sieve_limit_reg;
    logic [VAL_W-1:0] sieve_limit_next;
    emit_t            emit;
    logic             out_free;
    tbl_req_t         tbl_req;
    spf_entry_t       tbl_rdata;
    pr_req_t          pr_req;
    logic [VAL_W-1:0] pr_rdata;

    // Limit register: take every config transfer
    assign cfg_ready        = 1'b1;
    assign sieve_limit_next = (cfg_valid && cfg_ready) ? cfg_data : sieve_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sieve_limit_reg <= VAL_W'(MAX_VALUE);
        end
        else
        begin
            sieve_limit_reg <= sieve_limit_next;
        end
    end

    lsf_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .sieve_limit (sieve_limit_reg),
        .emit        (emit),
        .out_free    (out_free),
        .tbl_req     (tbl_req),
        .tbl_rdata   (tbl_rdata),
        .pr_req      (pr_req),
        .pr_rdata    (pr_rdata)
    );

    // Factor table: smallest prime factor and cofactor per value
    lsf_ram #(
        .DEPTH (TBL_DEPTH),
        .WIDTH ($bits(spf_entry_t))
    ) u_tbl_ram (
        .clk   (clk),
        .we    (tbl_req.we),
        .waddr (tbl_req.waddr),
        .wdata (tbl_req.wdata),
        .raddr (tbl_req.raddr),
        .rdata (tbl_rdata)
    );

    // Prime store, filled in increasing order during a build
    lsf_ram #(
        .DEPTH (PRIME_DEPTH),
        .WIDTH (VAL_W)
    ) u_prime_ram (
        .clk   (clk),
        .we    (pr_req.we),
        .waddr (pr_req.waddr),
        .wdata (pr_req.wdata),
        .raddr (pr_req.raddr),
        .rdata (pr_rdata)
    );

    lsf_outreg u_outreg (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

FILE: bench/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for linear_sieve_factorizer_core. A directed plan
// covers unbuilt queries, zero, one and out-of-range values, limits below
// two, the full table and eleven-factor values. Random phases follow, each
// with a new limit. Every result is checked against a bench-side sieve and
// factoriser or a fixed answer; random gaps and stalls on both channels.
// ============================================================================
module testbench
    import lsf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 150000;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_ITEMS    = 27;

    typedef enum logic {ROW_LIMIT, ROW_QUERY} row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic             op;
        logic [VAL_W-1:0] arg;
        logic             typed;
        out_item_t        answer;
    } plan_row_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [VAL_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_stall;
    in_item_t         in_data;
    logic             out_valid;
    logic             out_stall;
    out_item_t        out_data;

    // Bench copy of the factor table and its bookkeeping
    logic [VAL_W-1:0]  spf_tbl [0:MAX_VALUE];
    logic [VAL_W-1:0]  prime_list [0:PRIME_DEPTH-1];
    logic [PCNT_W-1:0] prime_total;
    logic [VAL_W-1:0]  built_upto;
    logic [VAL_W-1:0]  limit_reg;
    out_item_t         pending_results [$];
    out_item_t         head_result;
    plan_row_t         directed_plan [$];

    int error_count;
    int quiet_cycles;
    int stall_left;
    int free_left;
    int pick;
    bit free_run;

    linear_sieve_factorizer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    function automatic out_item_t make_result(logic [STAT_W-1:0] st, logic [VAL_W-1:0] f,
                                              logic [PCNT_W-1:0] cnt, logic lst);
        out_item_t r;
        r.status      = st;
        r.factor      = f;
        r.prime_count = cnt;
        r.last        = lst;
        return r;
    endfunction

    // Append one expected result behind those already waiting
    function automatic void queue_result(out_item_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Append one row to the directed plan
    function automatic void add_row(plan_row_t r);
        directed_plan.insert(directed_plan.size(), r);
    endfunction

    // Rebuild the table by the linear sieve up to the clamped limit
    function automatic void run_sieve();
        int lim;
        int stored;
        int p;
        int m;
        lim = int'(limit_reg);
        if (lim < 2)
            lim = 2;
        if (lim > MAX_VALUE)
            lim = MAX_VALUE;
        for (int a = 0; a <= MAX_VALUE; a++)
            spf_tbl[a] = '0;
        stored = 0;
        for (int i = 2; i <= lim; i++)
        begin
            if (spf_tbl[i] == 0)
            begin
                spf_tbl[i] = VAL_W'(i);
                if (stored < PRIME_DEPTH)
                begin
                    prime_list[stored] = VAL_W'(i);
                    stored++;
                end
            end
            for (int j = 0; j < stored; j++)
            begin
                p = int'(prime_list[j]);
                m = i * p;
                if (m > lim)
                    break;
                spf_tbl[m] = VAL_W'(p);
                if (p == int'(spf_tbl[i]))
                    break;
            end
        end
        prime_total = (stored > PCNT_MAX) ? PCNT_MAX[PCNT_W-1:0] : PCNT_W'(stored);
        built_upto  = VAL_W'(lim);
    endfunction

    // Append the results that one accepted item should produce
    function automatic void predict_answers(in_item_t it);
        logic [VAL_W-1:0] v;
        logic [VAL_W-1:0] f;
        logic [VAL_W-1:0] rest;
        int k;
        v = it.value;
        k = 0;
        if (it.operation == OP_BUILD)
        begin
            run_sieve();
            queue_result(make_result(ST_BUILT, '0, prime_total, 1'b1));
        end
        else if (built_upto == 0)
            queue_result(make_result(ST_NOT_BUILT, '0, '0, 1'b1));
        else if (v == 0 || v > built_upto)
            queue_result(make_result(ST_RANGE, '0, '0, 1'b1));
        else if (v == 1)
            queue_result(make_result(ST_ONE, '0, '0, 1'b1));
        else
        begin
            while (v != 1 && k < MAX_RESULTS)
            begin
                f = spf_tbl[v];
                if (f < 2)
                begin
                    // a damaged entry ends the query as out of range
                    queue_result(make_result(ST_RANGE, '0, '0, 1'b1));
                    break;
                end
                rest = v / f;
                queue_result(make_result(ST_FACTOR, f, '0,
                                         (rest == 1 || k == MAX_RESULTS - 1)));
                v = rest;
                k++;
            end
        end
    endfunction

    function automatic plan_row_t typed_row(logic op, logic [VAL_W-1:0] v,
                                            logic [STAT_W-1:0] st, logic [VAL_W-1:0] f,
                                            logic [PCNT_W-1:0] cnt);
        plan_row_t r;
        r.kind   = ROW_QUERY;
        r.op     = op;
        r.arg    = v;
        r.typed  = 1'b1;
        r.answer = make_result(st, f, cnt, 1'b1);
        return r;
    endfunction

    function automatic plan_row_t query_row(logic op, logic [VAL_W-1:0] v);
        plan_row_t r;
        r       = typed_row(op, v, ST_FACTOR, '0, '0);
        r.typed = 1'b0;
        return r;
    endfunction

    function automatic plan_row_t limit_row(logic [VAL_W-1:0] v);
        plan_row_t r;
        r      = typed_row(OP_BUILD, v, ST_BUILT, '0, '0);
        r.kind = ROW_LIMIT;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (free_run || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly in-range queries, some rebuilds, some rejected values
    function automatic in_item_t random_query();
        in_item_t it;
        int r;
        r            = $urandom_range(0, 99);
        it.operation = OP_FACTOR;
        it.value     = VAL_W'($urandom_range(0, MAX_VALUE));
        if (r < 5)
            it.operation = OP_BUILD;
        else if (r < 80 && built_upto >= 1)
            it.value = VAL_W'($urandom_range(1, built_upto));
        else if (r < 90)
            it.value = (built_upto == MAX_VALUE) ? '0
                       : VAL_W'($urandom_range(built_upto + 1, MAX_VALUE));
        return it;
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
        error_count++;
    endtask

    // Hold valid until the transfer, then record what the item should give
    task automatic send_item(in_item_t it, logic typed, out_item_t answer);
        int depth;
        int gap;
        in_data  = it;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        depth = pending_results.size();
        predict_answers(it);
        if (typed)
        begin
            while (pending_results.size() > depth)
                void'(pending_results.pop_back());
            queue_result(answer);
        end
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Drop valid and wait until every expected result has been taken
    task automatic drain_results();
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_limit(logic [VAL_W-1:0] v);
        drain_results();
        cfg_data  = v;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        limit_reg = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Receiver stall pattern: short and long stalls, free stretches
    always @(negedge clk)
    begin
        if (!rst_n || free_run)
            out_stall = 1'b0;
        else if (stall_left > 0)
        begin
            out_stall = 1'b1;
            stall_left--;
        end
        else if (free_left > 0)
        begin
            out_stall = 1'b0;
            free_left--;
        end
        else
        begin
            pick = $urandom_range(0, 15);
            if (pick < 2)
                stall_left = $urandom_range(10, 40);
            else if (pick < 6)
                stall_left = $urandom_range(1, 3);
            free_left = $urandom_range(1, 8);
            out_stall = 1'b0;
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing expected, status", 0,
                                int'(out_data.status));
            else
            begin
                head_result = pending_results.pop_front();
                if (out_data.status !== head_result.status)
                    report_mismatch("status", int'(head_result.status),
                                    int'(out_data.status));
                if (out_data.factor !== head_result.factor)
                    report_mismatch("factor", int'(head_result.factor),
                                    int'(out_data.factor));
                if (out_data.prime_count !== head_result.prime_count)
                    report_mismatch("prime_count", int'(head_result.prime_count),
                                    int'(out_data.prime_count));
                if (out_data.last !== head_result.last)
                    report_mismatch("last", int'(head_result.last), int'(out_data.last));
            end
        end
    end

    // Watchdog: end the run after too long without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        plan_row_t row;
        in_item_t  it;
        logic [VAL_W-1:0] lim;

        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        in_data      = '0;
        free_run     = 1'b0;
        error_count  = 0;
        quiet_cycles = 0;
        stall_left   = 0;
        free_left    = 0;
        prime_total  = '0;
        built_upto   = '0;
        limit_reg    = VAL_W'(MAX_VALUE);
        for (int a = 0; a <= MAX_VALUE; a++)
            spf_tbl[a] = '0;

        // Directed plan: unbuilt, full table, extremes, limits below two
        add_row(typed_row(OP_FACTOR, 12'd0, ST_NOT_BUILT, '0, '0));
        add_row(typed_row(OP_FACTOR, 12'd4095, ST_NOT_BUILT, '0, '0));
        add_row(typed_row(OP_BUILD, 12'd0, ST_BUILT, '0, 11'd564));
        add_row(typed_row(OP_FACTOR, 12'd0, ST_RANGE, '0, '0));
        add_row(typed_row(OP_FACTOR, 12'd1, ST_ONE, '0, '0));
        add_row(query_row(OP_FACTOR, 12'd4095));
        add_row(typed_row(OP_FACTOR, 12'd4093, ST_FACTOR, 12'd4093, '0));
        add_row(query_row(OP_FACTOR, 12'd2048));
        add_row(query_row(OP_FACTOR, 12'd3072));
        add_row(typed_row(OP_FACTOR, 12'd2, ST_FACTOR, 12'd2, '0));
        add_row(query_row(OP_FACTOR, 12'd4094));
        add_row(query_row(OP_FACTOR, 12'd2730));
        add_row(query_row(OP_FACTOR, 12'd3481));
        add_row(limit_row(12'd0));
        add_row(typed_row(OP_BUILD, 12'd4095, ST_BUILT, '0, 11'd1));
        add_row(typed_row(OP_FACTOR, 12'd2, ST_FACTOR, 12'd2, '0));
        add_row(typed_row(OP_FACTOR, 12'd3, ST_RANGE, '0, '0));
        add_row(typed_row(OP_FACTOR, 12'd4095, ST_RANGE, '0, '0));
        add_row(limit_row(12'd1));
        add_row(typed_row(OP_BUILD, 12'hAAA, ST_BUILT, '0, 11'd1));
        add_row(typed_row(OP_FACTOR, 12'd1, ST_ONE, '0, '0));
        add_row(limit_row(12'd3));
        add_row(typed_row(OP_BUILD, 12'h555, ST_BUILT, '0, 11'd2));
        add_row(typed_row(OP_FACTOR, 12'd3, ST_FACTOR, 12'd3, '0));
        add_row(typed_row(OP_FACTOR, 12'd4, ST_RANGE, '0, '0));

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk the directed plan
        foreach (directed_plan[n])
        begin
            row = directed_plan[n];
            if (row.kind == ROW_LIMIT)
                write_limit(row.arg);
            else
            begin
                it.operation = row.op;
                it.value     = row.arg;
                send_item(it, row.typed, row.answer);
            end
        end

        // Random phases: new limit, rebuild, then mixed queries
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == 0)
                lim = VAL_W'(MAX_VALUE);
            else if (ph == 1)
                lim = VAL_W'($urandom_range(0, 1));
            else if (ph == 2)
                lim = VAL_W'($urandom_range(3, 64));
            else if (ph == 3)
                lim = VAL_W'($urandom_range(401, MAX_VALUE - 1));
            else
                lim = VAL_W'($urandom_range(2, 400));
            write_limit(lim);
            free_run     = (ph == 2 || ph == 5);
            it.operation = OP_BUILD;
            it.value     = VAL_W'($urandom_range(0, MAX_VALUE));
            send_item(it, 1'b0, head_result);
            for (int n = 1; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 19) == 0)
                    drain_results();
                send_item(random_query(), 1'b0, head_result);
            end
            free_run = 1'b0;
        end

        // Let everything arrive, then watch for stray results
        drain_results();
        repeat (16) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never arrived, count", 0, pending_results.size());
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
src/lsf_pkg.sv
src/lsf_ram.sv
src/lsf_outreg.sv
src/lsf_seq.sv
src/linear_sieve_factorizer_core.sv
bench/testbench.sv
